### rtl/stb_pkg.sv
// shared types and constants for the software timer bank
// no dependencies
`default_nettype none

package stb_pkg;

    localparam int TIMER_SLOTS_DEF = 16;

    localparam int OP_W      = 2;
    localparam int SLOT_W    = 4;
    localparam int COUNT_W   = 16;
    localparam int MS_W      = 16;
    localparam int RATE_W    = 24;
    localparam int TICKS_W   = 32;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;

    // ms * rate / 1000 is split as ms * (rate / 1000) + ms * (rate % 1000) / 1000
    localparam int RATE_Q_W      = 15;
    localparam int RATE_R_W      = 10;
    localparam int LO_W          = MS_W + RATE_R_W;
    localparam int RECIP_RATE_W  = 22;
    localparam int RECIP_RATE_SH = 28;
    localparam int RECIP_LO_W    = 24;
    localparam int RECIP_LO_SH   = 30;
    localparam int DIV_STEPS     = 3;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

    // reciprocals of 125, applied after dropping three low bits
    localparam logic [RECIP_RATE_W-1:0] RECIP_RATE = 22'd2147484;
    localparam logic [RECIP_LO_W-1:0]   RECIP_LO   = 24'd8589935;

    localparam logic [RATE_R_W-1:0]  MS_PER_S    = 10'd1000;
    localparam logic [TICKS_W-1:0]   NONE_ACTIVE = 32'hFFFF_FFFF;
    localparam logic [TICKS_W-1:0]   CMP_RANGE   = 32'h0001_0000;

    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_START  = 2'd1;
    localparam logic [OP_W-1:0] OP_RESUME = 2'd2;
    localparam logic [OP_W-1:0] OP_STOP   = 2'd3;

    localparam logic [KIND_W-1:0] KIND_EXPIRY  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MS    = 2'd2;

    localparam logic [RATE_W-1:0] RATE_RESET = 24'd32768;
    localparam logic [MS_W-1:0]   MIN_RESET  = 16'd1;
    localparam logic [MS_W-1:0]   MAX_RESET  = 16'd65535;

    typedef struct packed {
        logic latch;
        logic stop_rd;
        logic stop_upd;
        logic mul;
        logic div_step;
        logic new_wr;
        logic walk_init;
        logic walk_rd;
        logic summ;
        logic reply;
    } stb_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            range_ok;
        logic            dead;
    } stb_status_t;

endpackage

`default_nettype wire

### rtl/stb_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module stb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/stb_ctrl.sv
// sequencer for the timer bank: stop, convert, slot walk, summary and done reply
// depends on stb_pkg
`default_nettype none

module stb_ctrl #(
    parameter int TIMER_SLOTS = stb_pkg::TIMER_SLOTS_DEF,
    parameter int IDX_W = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [stb_pkg::OP_W-1:0]   op,
    input  wire logic [stb_pkg::SLOT_W-1:0] slot,
    input  wire stb_pkg::stb_status_t       status,
    output stb_pkg::stb_cmd_t               cmd,
    output logic      [IDX_W-1:0]           walk_idx,
    output logic                            busy
);

    localparam int CNT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_SREAD = 12'b0000_0000_0010,
        S_SUPD  = 12'b0000_0000_0100,
        S_MUL   = 12'b0000_0000_1000,
        S_DIV   = 12'b0000_0001_0000,
        S_NEWW  = 12'b0000_0010_0000,
        S_CHECK = 12'b0000_0100_0000,
        S_WINIT = 12'b0000_1000_0000,
        S_WALK  = 12'b0001_0000_0000,
        S_DRAIN = 12'b0010_0000_0000,
        S_SUMM  = 12'b0100_0000_0000,
        S_REPLY = 12'b1000_0000_0000
    } state_t;

    state_t                           state_reg, state_next;
    logic [CNT_W-1:0]                 walk_cnt_reg, walk_cnt_next;
    logic [stb_pkg::DIV_CNT_W-1:0]    div_cnt_reg, div_cnt_next;
    logic                             slot_ok;

    assign slot_ok  = 32'(slot) < TIMER_SLOTS;
    assign busy     = (state_reg != S_IDLE);
    assign walk_idx = IDX_W'(walk_cnt_reg);

    always_comb
    begin
        state_next    = state_reg;
        walk_cnt_next = walk_cnt_reg;
        div_cnt_next  = div_cnt_reg;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch = 1'b1;
                    if (op == stb_pkg::OP_TICK)
                    begin
                        state_next = S_WINIT;
                    end
                    else if (!slot_ok)
                    begin
                        state_next = S_REPLY;
                    end
                    else
                    begin
                        state_next = S_SREAD;
                    end
                end
            end
            S_SREAD:
            begin
                cmd.stop_rd = 1'b1;
                state_next  = S_SUPD;
            end
            S_SUPD:
            begin
                cmd.stop_upd = 1'b1;
                case (status.op)
                    stb_pkg::OP_START:  state_next = status.range_ok ? S_MUL : S_REPLY;
                    stb_pkg::OP_RESUME: state_next = S_CHECK;
                    default:            state_next = S_REPLY;
                endcase
            end
            S_MUL:
            begin
                cmd.mul      = 1'b1;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == stb_pkg::DIV_CNT_W'(stb_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_NEWW;
                end
            end
            S_NEWW:
            begin
                cmd.new_wr = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = status.dead ? S_REPLY : S_WINIT;
            end
            S_WINIT:
            begin
                cmd.walk_init = 1'b1;
                walk_cnt_next = '0;
                state_next    = S_WALK;
            end
            S_WALK:
            begin
                cmd.walk_rd   = 1'b1;
                walk_cnt_next = walk_cnt_reg + 1'b1;
                if (walk_cnt_reg == CNT_W'(TIMER_SLOTS - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_SUMM;
            end
            S_SUMM:
            begin
                cmd.summ   = 1'b1;
                state_next = S_IDLE;
            end
            S_REPLY:
            begin
                cmd.reply  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            walk_cnt_reg <= '0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            walk_cnt_reg <= walk_cnt_next;
            div_cnt_reg  <= div_cnt_next;
        end
    end

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not make the block busy");
    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (32'(walk_cnt_reg) < TIMER_SLOTS))
        else $error("slot walk beyond bank");
    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (32'(div_cnt_reg) < stb_pkg::DIV_STEPS))
        else $error("divider ran too long");
    a_one_cmd_out: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.summ, cmd.reply, cmd.walk_rd, cmd.div_step}))
        else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

### rtl/stb_dp.sv
// datapath of the timer bank: slot store, converter, charge and summary
// depends on stb_pkg and stb_ram
`default_nettype none

module stb_dp #(
    parameter int TIMER_SLOTS = stb_pkg::TIMER_SLOTS_DEF,
    parameter int IDX_W = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire stb_pkg::stb_cmd_t             cmd,
    input  wire logic [IDX_W-1:0]              walk_idx,
    output stb_pkg::stb_status_t               status,
    input  wire logic [stb_pkg::OP_W-1:0]      op,
    input  wire logic [stb_pkg::SLOT_W-1:0]    slot,
    input  wire logic [stb_pkg::COUNT_W-1:0]   now,
    input  wire logic [stb_pkg::MS_W-1:0]      period_ms,
    input  wire logic                          repeat_req,
    input  wire logic                          cfg_we,
    input  wire logic [stb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [stb_pkg::RATE_W-1:0]    cfg_data,
    output logic                               result_valid,
    output logic      [stb_pkg::KIND_W-1:0]    kind,
    output logic      [stb_pkg::SLOT_W-1:0]    expired_slot,
    output logic      [stb_pkg::TICKS_W-1:0]   min_ticks,
    output logic      [stb_pkg::COUNT_W-1:0]   compare_value,
    output logic                               compare_enable,
    output logic                               last
);

    localparam int TW   = stb_pkg::TICKS_W;
    localparam int PA_W = stb_pkg::RATE_W - 3 + stb_pkg::RECIP_RATE_W;
    localparam int PB_W = stb_pkg::LO_W - 3 + stb_pkg::RECIP_LO_W;

    logic [stb_pkg::RATE_W-1:0]  rate_reg;
    logic [stb_pkg::MS_W-1:0]    min_reg, max_reg;
    logic [stb_pkg::OP_W-1:0]    op_reg;
    logic [stb_pkg::SLOT_W-1:0]  slot_reg;
    logic [stb_pkg::COUNT_W-1:0] now_reg, last_count_reg, el_reg;
    logic [stb_pkg::MS_W-1:0]    ms_reg;
    logic                        rep_reg;
    logic [TIMER_SLOTS-1:0]      active_reg, written_reg;
    logic [TW-1:0]               rem_s_reg, rel_s_reg, m_reg;
    logic [stb_pkg::RATE_Q_W-1:0] rate_q_reg;
    logic [stb_pkg::RATE_R_W-1:0] rate_r_reg;
    logic [TW-1:0]               hi_reg, quot_reg;
    logic [stb_pkg::LO_W-1:0]    lo_reg;
    logic                        proc_vld_reg, rd_written_reg;
    logic [IDX_W-1:0]            proc_idx_reg;

    logic                        out_vld_reg, out_last_reg, out_en_reg;
    logic [stb_pkg::KIND_W-1:0]  out_kind_reg;
    logic [stb_pkg::SLOT_W-1:0]  out_slot_reg;
    logic [TW-1:0]               out_tmin_reg;
    logic [stb_pkg::COUNT_W-1:0] out_cmp_reg;

    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr, ram_raddr, s_idx;
    logic [2*TW-1:0]             ram_wdata, ram_rdata;
    logic [TW-1:0]               rd_rem, rd_rel, el32, stop_rem, new_rel, fin_m;
    logic [stb_pkg::COUNT_W-1:0] el_now;
    logic                        s_active, p_act, p_exp;
    logic [PA_W-1:0]             rate_prod;
    logic [PB_W-1:0]             lo_prod;
    logic [stb_pkg::RATE_W-1:0]  rate_r_full;

    assign s_idx    = IDX_W'(slot_reg);
    assign rd_rem   = rd_written_reg ? ram_rdata[2*TW-1:TW] : '0;
    assign rd_rel   = rd_written_reg ? ram_rdata[TW-1:0] : '0;
    assign el_now   = now_reg - last_count_reg;
    assign s_active = active_reg[s_idx];
    assign stop_rem = (rd_rem <= TW'(el_now)) ? rd_rel : rd_rem - TW'(el_now);
    assign el32     = TW'(el_reg);
    assign p_act    = proc_vld_reg && active_reg[proc_idx_reg];
    assign p_exp    = rd_rem <= el32;
    assign new_rel  = rep_reg ? quot_reg : '0;
    assign fin_m    = (op_reg != stb_pkg::OP_TICK && rem_s_reg < m_reg) ? rem_s_reg : m_reg;

    // divide by 1000 as a shift by three and a reciprocal multiply by 1/125
    assign rate_prod   = PA_W'(rate_reg[stb_pkg::RATE_W-1:3]) * PA_W'(stb_pkg::RECIP_RATE);
    assign rate_r_full = rate_reg - stb_pkg::RATE_W'(rate_q_reg) *
                                    stb_pkg::RATE_W'(stb_pkg::MS_PER_S);
    assign lo_prod     = PB_W'(lo_reg[stb_pkg::LO_W-1:3]) * PB_W'(stb_pkg::RECIP_LO);

    assign status.op       = op_reg;
    assign status.range_ok = (ms_reg >= min_reg) && (ms_reg <= max_reg);
    assign status.dead     = (rem_s_reg == '0) && (rel_s_reg == '0);

    assign ram_raddr = cmd.stop_rd ? s_idx : walk_idx;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = s_idx;
        ram_wdata = {stop_rem, rd_rel};
        if (cmd.stop_upd)
        begin
            ram_we = s_active;
        end
        else if (cmd.new_wr)
        begin
            ram_we    = 1'b1;
            ram_wdata = {quot_reg, new_rel};
        end
        else if (p_act)
        begin
            ram_we    = !(p_exp && rd_rel == '0);
            ram_waddr = proc_idx_reg;
            ram_wdata = {p_exp ? rd_rel : rd_rem - el32, rd_rel};
        end
    end

    stb_ram #(
        .WIDTH(2 * TW),
        .DEPTH(TIMER_SLOTS),
        .ADDR_W(IDX_W)
    ) u_ram (
        .clk(clk),
        .we(ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= op;
            slot_reg <= slot;
            now_reg  <= now;
            ms_reg   <= period_ms;
            rep_reg  <= repeat_req;
        end
        if (cmd.stop_upd)
        begin
            rem_s_reg <= s_active ? stop_rem : rd_rem;
            rel_s_reg <= rd_rel;
        end
        if (cmd.new_wr)
        begin
            rem_s_reg <= quot_reg;
            rel_s_reg <= new_rel;
        end
        if (cmd.mul)
        begin
            rate_q_reg <= rate_prod[PA_W-1:stb_pkg::RECIP_RATE_SH];
        end
        // three step pipeline, settled after the last step
        if (cmd.div_step)
        begin
            rate_r_reg <= rate_r_full[stb_pkg::RATE_R_W-1:0];
            hi_reg     <= TW'(ms_reg) * TW'(rate_q_reg);
            lo_reg     <= stb_pkg::LO_W'(ms_reg) * stb_pkg::LO_W'(rate_r_reg);
            quot_reg   <= hi_reg + TW'(lo_prod[PB_W-1:stb_pkg::RECIP_LO_SH]);
        end
        if (cmd.walk_init)
        begin
            el_reg <= el_now;
            m_reg  <= stb_pkg::NONE_ACTIVE;
        end
        if (p_act)
        begin
            if (p_exp)
            begin
                if (rd_rel != '0 && rd_rel < m_reg)
                begin
                    m_reg <= rd_rel;
                end
            end
            else if (rd_rem - el32 < m_reg)
            begin
                m_reg <= rd_rem - el32;
            end
        end
        proc_idx_reg   <= ram_raddr;
        rd_written_reg <= written_reg[ram_raddr];

        if (p_act && p_exp)
        begin
            out_kind_reg <= stb_pkg::KIND_EXPIRY;
            out_slot_reg <= stb_pkg::SLOT_W'(proc_idx_reg);
            out_tmin_reg <= '0;
            out_cmp_reg  <= '0;
            out_en_reg   <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else if (cmd.summ)
        begin
            out_kind_reg <= stb_pkg::KIND_SUMMARY;
            out_slot_reg <= '0;
            out_tmin_reg <= fin_m;
            out_cmp_reg  <= (fin_m < stb_pkg::CMP_RANGE) ?
                            now_reg + fin_m[stb_pkg::COUNT_W-1:0] : now_reg;
            out_en_reg   <= (fin_m != stb_pkg::NONE_ACTIVE);
            out_last_reg <= 1'b1;
        end
        else
        begin
            out_kind_reg <= stb_pkg::KIND_DONE;
            out_slot_reg <= '0;
            out_tmin_reg <= '0;
            out_cmp_reg  <= '0;
            out_en_reg   <= 1'b0;
            out_last_reg <= 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg       <= stb_pkg::RATE_RESET;
            min_reg        <= stb_pkg::MIN_RESET;
            max_reg        <= stb_pkg::MAX_RESET;
            active_reg     <= '0;
            written_reg    <= '0;
            last_count_reg <= '0;
            proc_vld_reg   <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    stb_pkg::CFG_TICK_RATE: rate_reg <= cfg_data;
                    stb_pkg::CFG_MIN_MS:    min_reg  <= cfg_data[stb_pkg::MS_W-1:0];
                    stb_pkg::CFG_MAX_MS:    max_reg  <= cfg_data[stb_pkg::MS_W-1:0];
                    default:                ;
                endcase
            end
            if (ram_we)
            begin
                written_reg[ram_waddr] <= 1'b1;
            end
            if (cmd.stop_upd)
            begin
                active_reg[s_idx] <= 1'b0;
            end
            if (cmd.walk_init && active_reg != '0)
            begin
                last_count_reg <= now_reg;
            end
            if (p_act && p_exp && rd_rel == '0)
            begin
                active_reg[proc_idx_reg] <= 1'b0;
            end
            if (cmd.summ && op_reg != stb_pkg::OP_TICK)
            begin
                active_reg[s_idx] <= 1'b1;
            end
            proc_vld_reg <= cmd.walk_rd;
            out_vld_reg  <= (p_act && p_exp) || cmd.summ || cmd.reply;
        end
    end

    assign result_valid   = out_vld_reg;
    assign kind           = out_kind_reg;
    assign expired_slot   = out_slot_reg;
    assign min_ticks      = out_tmin_reg;
    assign compare_value  = out_cmp_reg;
    assign compare_enable = out_en_reg;
    assign last           = out_last_reg;

endmodule

`default_nettype wire

### rtl/software_timer_bank_unit.sv
// top level of the software timer bank: controller plus datapath
// depends on stb_pkg, stb_ctrl, stb_dp
`default_nettype none

// An operation is taken when start is high and busy is low. A tick sets up,
// reads every slot in turn through the single read port of the slot store,
// drains and then gives the summary. A start with a new interval adds the
// store read and update, the split of the tick rate by 1000, the multiply
// and reciprocal divide steps, the store write and a check; resume adds the
// store read, update and check. A stop or an out-of-limits start gives its
// done beat after the store update, a slot outside the bank straight from
// acceptance, and a timer with nothing left to run after the check.
// Results appear for one cycle each under result_valid and cannot be held
// off; expiries come in slot order and the summary or done beat carries last.
module software_timer_bank_unit #(
    parameter int TIMER_SLOTS = stb_pkg::TIMER_SLOTS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [stb_pkg::OP_W-1:0]      op,
    input  wire logic [stb_pkg::SLOT_W-1:0]    slot,
    input  wire logic [stb_pkg::COUNT_W-1:0]   now,
    input  wire logic [stb_pkg::MS_W-1:0]      period_ms,
    input  wire logic                          repeat_req,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [stb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [stb_pkg::RATE_W-1:0]    cfg_data,
    output logic                               result_valid,
    output logic      [stb_pkg::KIND_W-1:0]    kind,
    output logic      [stb_pkg::SLOT_W-1:0]    expired_slot,
    output logic      [stb_pkg::TICKS_W-1:0]   min_ticks,
    output logic      [stb_pkg::COUNT_W-1:0]   compare_value,
    output logic                               compare_enable,
    output logic                               last
);

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    stb_pkg::stb_cmd_t    cmd;
    stb_pkg::stb_status_t status;
    logic [IDX_W-1:0]     walk_idx;
    logic                 busy_int;

    assign busy      = busy_int;
    assign cfg_ready = 1'b1;

    stb_ctrl #(
        .TIMER_SLOTS(TIMER_SLOTS),
        .IDX_W(IDX_W)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .op(op),
        .slot(slot),
        .status(status),
        .cmd(cmd),
        .walk_idx(walk_idx),
        .busy(busy_int)
    );

    stb_dp #(
        .TIMER_SLOTS(TIMER_SLOTS),
        .IDX_W(IDX_W)
    ) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .walk_idx(walk_idx),
        .status(status),
        .op(op),
        .slot(slot),
        .now(now),
        .period_ms(period_ms),
        .repeat_req(repeat_req),
        .cfg_we(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .result_valid(result_valid),
        .kind(kind),
        .expired_slot(expired_slot),
        .min_ticks(min_ticks),
        .compare_value(compare_value),
        .compare_enable(compare_enable),
        .last(last)
    );

endmodule

`default_nettype wire
